// File: sv/atrp_pkg.sv
// ----------------------------------------------------------------------------
// ARM relocation patcher package
// Item types, configuration types, relocation codes and field constants
// that are shared by the patcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package atrp_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 32;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_BLX_AVAILABLE  = 3'd0,
        CFG_GOT_BASE       = 3'd1,
        CFG_PLT_BASE       = 3'd2,
        CFG_PLT_BYTES      = 3'd3,
        CFG_OUTPUT_DYNAMIC = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        blx_available;
        logic [31:0] got_base;
        logic [31:0] plt_base;
        logic [23:0] plt_bytes;
        logic        output_dynamic;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  func;
        logic [31:0] insn_word;
        logic [31:0] place_addr;
        logic [31:0] sym_value;
        logic        sym_weak_undef;
        logic        sym_absolute;
        logic        sym_dynamic;
        logic [23:0] sym_got_offset;
    } req_t;

    typedef struct packed {
        logic [31:0] new_word;
        logic [1:0]  status;
        logic [1:0]  dyn_reloc;
    } rsp_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_RANGE   = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

    localparam logic [1:0] DYN_NONE     = 2'd0;
    localparam logic [1:0] DYN_ABS32    = 2'd1;
    localparam logic [1:0] DYN_RELATIVE = 2'd2;

    localparam logic [7:0] R_NONE            = 8'd0;
    localparam logic [7:0] R_PC24            = 8'd1;
    localparam logic [7:0] R_ABS32           = 8'd2;
    localparam logic [7:0] R_REL32           = 8'd3;
    localparam logic [7:0] R_THM_PC22        = 8'd10;
    localparam logic [7:0] R_THM_PC8         = 8'd11;
    localparam logic [7:0] R_COPY            = 8'd20;
    localparam logic [7:0] R_GLOB_DAT        = 8'd21;
    localparam logic [7:0] R_JUMP_SLOT       = 8'd22;
    localparam logic [7:0] R_RELATIVE        = 8'd23;
    localparam logic [7:0] R_GOTOFF          = 8'd24;
    localparam logic [7:0] R_GOTPC           = 8'd25;
    localparam logic [7:0] R_GOT32           = 8'd26;
    localparam logic [7:0] R_PLT32           = 8'd27;
    localparam logic [7:0] R_CALL            = 8'd28;
    localparam logic [7:0] R_JUMP24          = 8'd29;
    localparam logic [7:0] R_THM_JUMP24      = 8'd30;
    localparam logic [7:0] R_TARGET1         = 8'd38;
    localparam logic [7:0] R_V4BX            = 8'd40;
    localparam logic [7:0] R_PREL31          = 8'd42;
    localparam logic [7:0] R_MOVW_ABS_NC     = 8'd43;
    localparam logic [7:0] R_MOVT_ABS        = 8'd44;
    localparam logic [7:0] R_MOVW_PREL_NC    = 8'd45;
    localparam logic [7:0] R_MOVT_PREL       = 8'd46;
    localparam logic [7:0] R_THM_MOVW_ABS_NC = 8'd47;
    localparam logic [7:0] R_THM_MOVT_ABS    = 8'd48;
    localparam logic [7:0] R_THM_JUMP6       = 8'd52;
    localparam logic [7:0] R_THM_ALU_PREL    = 8'd53;
    localparam logic [7:0] R_THM_PC12        = 8'd54;
    localparam logic [7:0] R_GOT_PREL        = 8'd96;

    localparam logic [7:0]  ARM_BL_OPCODE   = 8'heb;
    localparam logic [6:0]  ARM_BLX_PREFIX  = 7'h7d;
    localparam logic [15:0] THM_NOP         = 16'hbf00;
    localparam logic [15:0] ALU_HI_KEEP     = 16'hfb0f;
    localparam logic [15:0] ALU_LO_KEEP     = 16'h8f00;
    localparam logic [15:0] ALU_SUB_BITS    = 16'h00a0;
    localparam logic [15:0] LDR_U_CLEAR     = 16'hff7f;
    localparam logic [15:0] BR_HI_KEEP      = 16'hf800;
    localparam logic [15:0] BR_LO_KEEP      = 16'hd000;
    localparam logic [31:0] MOV_KEEP        = 32'hfff0f000;
    localparam logic [31:0] BX_MASK         = 32'h0ffffff0;
    localparam logic [31:0] BX_PATTERN      = 32'h012fff10;
    localparam logic [31:0] BX_TO_MOV       = 32'he12fff10 ^ 32'he1a0f000;

endpackage : atrp_pkg

`default_nettype wire

// File: sv/atrp_cfg.sv
// ----------------------------------------------------------------------------
// ARM relocation patcher configuration registers
// Holds the link-time settings written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module atrp_cfg
    import atrp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BLX_AVAILABLE:  cfg_next.blx_available  = cfg_data[0];
                CFG_GOT_BASE:       cfg_next.got_base       = cfg_data;
                CFG_PLT_BASE:       cfg_next.plt_base       = cfg_data;
                CFG_PLT_BYTES:      cfg_next.plt_bytes      = cfg_data[23:0];
                CFG_OUTPUT_DYNAMIC: cfg_next.output_dynamic = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blx_available  <= 1'b1;
            cfg_reg.got_base       <= '0;
            cfg_reg.plt_base       <= '0;
            cfg_reg.plt_bytes      <= '0;
            cfg_reg.output_dynamic <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : atrp_cfg

`default_nettype wire

// File: sv/atrp_core.sv
// ----------------------------------------------------------------------------
// ARM relocation patcher datapath
// Combinational patch of one relocation item: field extraction, offset
// arithmetic, range checks and reinsertion of the new fields.
// ----------------------------------------------------------------------------
`default_nettype none

module atrp_core
    import atrp_pkg::*;
(
    input  cfg_t cfg,
    input  req_t req,
    output rsp_t rsp
);

    always_comb
    begin
        logic [31:0] w;
        logic [31:0] val;
        logic [31:0] place;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [31:0] vsp;
        logic [31:0] x;
        logic [31:0] d;
        logic [31:0] mag;
        logic        neg;
        logic        is_call;
        logic        to_plt;
        logic        s;
        logic        i1;
        logic        i2;
        logic [15:0] y;
        logic [31:0] tx;
        logic [1:0]  status;
        logic [1:0]  dr;

        w      = req.insn_word;
        val    = req.sym_value;
        place  = req.place_addr;
        hi     = w[15:0];
        lo     = w[31:16];
        vsp    = val - place;
        d      = val - ({place[31:2], 2'b00} + 32'd4);
        neg    = d[31];
        mag    = neg ? (32'd0 - d) : d;
        status = STATUS_OK;
        dr     = DYN_NONE;
        x      = '0;
        is_call = 1'b0;
        to_plt  = 1'b0;
        s  = 1'b0;
        i1 = 1'b0;
        i2 = 1'b0;
        y  = '0;
        tx = '0;

        case (req.func)
            R_PC24, R_CALL, R_JUMP24, R_PLT32:
            begin
                is_call = (req.func == R_CALL) ||
                          ((req.func == R_PC24) && (w[31:24] == ARM_BL_OPCODE));
                x = {{6{w[23]}}, w[23:0], 2'b00} + vsp;
                if (((x[1:0] != 2'b00) && (!cfg.blx_available || !is_call)) ||
                    ((x[31:25] != 7'h00) && (x[31:25] != 7'h7f)))
                begin
                    status = STATUS_RANGE;
                end
                if (val[0])
                begin
                    w = {ARM_BLX_PREFIX, x[1], x[25:2]};
                end
                else
                begin
                    w = {w[31:24], x[25:2]};
                end
            end
            R_THM_JUMP6:
            begin
                if (!req.sym_weak_undef)
                begin
                    x = vsp - 32'd4;
                    if (x[31])
                    begin
                        hi = THM_NOP;
                    end
                    else
                    begin
                        if (x[30:7] != '0)
                        begin
                            status = STATUS_RANGE;
                        end
                        hi = hi | {6'b0, x[6], 1'b0, x[5:1], 3'b000};
                    end
                    w = {lo, hi};
                end
            end
            R_THM_ALU_PREL:
            begin
                if (!req.sym_weak_undef)
                begin
                    if (mag[31:12] != '0)
                    begin
                        status = STATUS_RANGE;
                    end
                    hi = (hi & ALU_HI_KEEP) | {5'b0, mag[11], 10'b0} |
                         (neg ? ALU_SUB_BITS : 16'h0000);
                    lo = (lo & ALU_LO_KEEP) | {1'b0, mag[10:8], 4'b0, mag[7:0]};
                    w = {lo, hi};
                end
            end
            R_THM_PC12, R_THM_PC8:
            begin
                if (!req.sym_weak_undef)
                begin
                    if (neg)
                    begin
                        hi = hi & LDR_U_CLEAR;
                    end
                    if (req.func == R_THM_PC12)
                    begin
                        if (mag[31:12] != '0)
                        begin
                            status = STATUS_RANGE;
                        end
                        lo = lo | {4'b0, mag[11:0]};
                    end
                    else
                    begin
                        if (mag[31:10] != '0)
                        begin
                            status = STATUS_RANGE;
                        end
                        lo = lo | {8'b0, mag[9:2]};
                    end
                    w = {lo, hi};
                end
            end
            R_THM_PC22, R_THM_JUMP24:
            begin
                if (!req.sym_weak_undef)
                begin
                    is_call = (req.func == R_THM_PC22);
                    to_plt  = (cfg.plt_bytes != '0) &&
                              ((val - cfg.plt_base) < {8'b0, cfg.plt_bytes});
                    s  = hi[10];
                    i1 = ~(lo[13] ^ s);
                    i2 = ~(lo[11] ^ s);
                    x = {{7{s}}, s, i1, i2, hi[9:0], lo[10:0], 1'b0} + vsp;
                    if ((x[31:24] != 8'h00) && (x[31:24] != 8'hff) &&
                        (val[1] || (!is_call && !to_plt)))
                    begin
                        status = STATUS_RANGE;
                    end
                    s  = x[24];
                    i1 = x[23];
                    i2 = x[22];
                    hi = (hi & BR_HI_KEEP) | {5'b0, s, x[21:12]};
                    lo = (lo & BR_LO_KEEP) |
                         {2'b00, ~(s ^ i1), ~is_call, ~(s ^ i2), x[11:1]};
                    w = {lo, hi};
                end
            end
            R_MOVT_ABS, R_MOVW_ABS_NC:
            begin
                y = (req.func == R_MOVT_ABS) ? val[31:16] : val[15:0];
                w = w + {12'b0, y[15:12], 4'b0, y[11:0]};
            end
            R_MOVT_PREL, R_MOVW_PREL_NC:
            begin
                x = vsp + {{16{w[19]}}, w[19:16], w[11:0]};
                y = (req.func == R_MOVT_PREL) ? x[31:16] : x[15:0];
                w = (w & MOV_KEEP) | {12'b0, y[15:12], 4'b0, y[11:0]};
            end
            R_THM_MOVT_ABS, R_THM_MOVW_ABS_NC:
            begin
                y  = (req.func == R_THM_MOVT_ABS) ? val[31:16] : val[15:0];
                tx = {1'b0, y[10:8], 4'b0, y[7:0], 5'b0, y[11], 6'b0, y[15:12]};
                if (req.func == R_THM_MOVT_ABS)
                begin
                    w = w | tx;
                end
                else
                begin
                    w = w + tx;
                end
            end
            R_PREL31:
            begin
                x = {w[30], w[30:0]} + vsp;
                if (x[31] != x[30])
                begin
                    status = STATUS_RANGE;
                end
                w = {w[31], x[30:0]};
            end
            R_ABS32, R_TARGET1:
            begin
                if (cfg.output_dynamic && req.sym_dynamic)
                begin
                    dr = DYN_ABS32;
                    if (req.sym_absolute)
                    begin
                        w = w + val;
                    end
                end
                else
                begin
                    if (cfg.output_dynamic)
                    begin
                        dr = DYN_RELATIVE;
                    end
                    w = w + val;
                end
            end
            R_REL32:
            begin
                w = w + vsp;
            end
            R_GOTPC:
            begin
                w = w + (cfg.got_base - place);
            end
            R_GOTOFF:
            begin
                w = w + (val - cfg.got_base);
            end
            R_GOT32:
            begin
                w = {8'b0, req.sym_got_offset};
            end
            R_GOT_PREL:
            begin
                w = cfg.got_base + {8'b0, req.sym_got_offset} - place - 32'd8;
            end
            R_V4BX:
            begin
                if ((w & BX_MASK) == BX_PATTERN)
                begin
                    w = w ^ BX_TO_MOV;
                end
            end
            R_GLOB_DAT, R_JUMP_SLOT:
            begin
                w = val;
            end
            R_NONE, R_COPY, R_RELATIVE:
            begin
                w = req.insn_word;
            end
            default:
            begin
                status = STATUS_UNKNOWN;
            end
        endcase

        rsp.new_word  = w;
        rsp.status    = status;
        rsp.dyn_reloc = dr;
    end

endmodule : atrp_core

`default_nettype wire

// File: sv/arm_thumb_relocation_patcher.sv
// ----------------------------------------------------------------------------
// ARM and Thumb relocation patcher
// Applies one ELF ARM relocation to the word at its place and reports the
// patched word, a range status and the dynamic relocation to emit.
//
// An item is accepted at a rising edge where start is high and busy is low.
// Busy never rises, so a new item may be given in every cycle.
// The accepted item is held in an input register; the patch logic runs in
// the following cycle and its result is captured in the result register.
// The result appears on rsp with done high for exactly one cycle, from the
// edge after the accepting edge, and items leave in the order they came.
// The sustained rate is one item per clock, set by the single pass through
// the patch logic between the two registers.
// The receiver cannot hold results off, so nothing ever stalls.
// The configuration registers are written through cfg_we, cfg_index and
// cfg_data; the user must do so only while no item is in flight (unenforced).
// Reset clears the pipeline valid flags and loads the register defaults:
// BLX allowed, GOT and PLT bases zero, no PLT, static output.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_thumb_relocation_patcher
    import atrp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  req_t                          req,
    output logic                          done,
    output rsp_t                          rsp,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data
);

    cfg_t cfg;
    req_t req_reg;
    logic req_valid_reg;
    rsp_t rsp_next;
    rsp_t rsp_reg;
    logic done_reg;

    atrp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    atrp_core u_core (
        .cfg (cfg),
        .req (req_reg),
        .rsp (rsp_next)
    );

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule : arm_thumb_relocation_patcher

`default_nettype wire
